@@ hw/rtl/tevq_pkg.sv @@
// ============================================================================
// tevq_pkg: shared types and constants for the timed event queue
// Payload words, action and status codes, and controller/datapath links.
// ============================================================================
`default_nettype none

package tevq_pkg;

    // Default sizes
    localparam int QueueDepthDef  = 16;
    localparam int NodeBitsDef    = 8;
    localparam int PacketBitsDef  = 16;

    // Field constants
    localparam logic [7:0]  NONE_ID     = 8'hFF;
    localparam logic [31:0] TIME_RESET  = 32'd1;
    localparam logic [1:0]  KIND_CREATE = 2'd0;
    localparam logic [1:0]  KIND_UPLOAD = 2'd2;

    // Input action codes
    typedef enum logic [1:0] {
        ACT_SCHED   = 2'd0,
        ACT_DRAIN   = 2'd1,
        ACT_ADVANCE = 2'd2
    } t_action;

    // Result status codes
    typedef enum logic [2:0] {
        ST_SCHEDULED = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_DUE       = 3'd2,
        ST_NONE_DUE  = 3'd3,
        ST_ADVANCED  = 3'd4
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Input word
    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  job_kind;
        logic [7:0]  node_id;
        logic [7:0]  dest_id;
        logic [7:0]  link_id;
        logic [15:0] packet_ref;
        logic [15:0] delay;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  job_kind_res;
        logic [7:0]  node_id_res;
        logic [7:0]  dest_id_res;
        logic [7:0]  link_id_res;
        logic [15:0] packet_ref_res;
        logic [31:0] now_time;
        logic        last;
    } t_out_word;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    insert;
        logic    pop;
        logic    tick;
        logic    emit;
        t_status res_status;
        logic    res_last;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_action action;
        logic    full;
        logic    head_due;
        logic    next_due;
        logic    out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hw/rtl/tevq_ctrl.sv @@
// ============================================================================
// tevq_ctrl: sequencing controller for the timed event queue
// Accepts one word, then runs schedule, drain or advance against the datapath.
// ============================================================================
`default_nettype none

module tevq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tevq_pkg::t_dp_stat i_stat,
    output tevq_pkg::t_dp_cmd       o_cmd
);

    tevq_pkg::t_state r_state;
    tevq_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tevq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tevq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tevq_pkg::S_EXEC;
                end
            end
            tevq_pkg::S_EXEC: begin
                unique case (i_stat.action) inside
                    tevq_pkg::ACT_SCHED, tevq_pkg::ACT_ADVANCE: begin
                        if (i_stat.out_free) begin
                            n_state = tevq_pkg::S_IDLE;
                        end
                    end
                    tevq_pkg::ACT_DRAIN: begin
                        // stay while another job is due behind the head
                        if (i_stat.out_free && !(i_stat.head_due && i_stat.next_due)) begin
                            n_state = tevq_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        n_state = tevq_pkg::S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = tevq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.res_status = tevq_pkg::ST_SCHEDULED;
        unique case (r_state)
            tevq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tevq_pkg::S_EXEC: begin
                if (i_stat.out_free) begin
                    unique case (i_stat.action)
                        tevq_pkg::ACT_SCHED: begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.res_last = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.res_status = tevq_pkg::ST_DROPPED;
                            end else begin
                                o_cmd.insert     = 1'b1;
                                o_cmd.res_status = tevq_pkg::ST_SCHEDULED;
                            end
                        end
                        tevq_pkg::ACT_DRAIN: begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.head_due) begin
                                o_cmd.pop        = 1'b1;
                                o_cmd.res_status = tevq_pkg::ST_DUE;
                                o_cmd.res_last   = !i_stat.next_due;
                            end else begin
                                o_cmd.res_status = tevq_pkg::ST_NONE_DUE;
                                o_cmd.res_last   = 1'b1;
                            end
                        end
                        tevq_pkg::ACT_ADVANCE: begin
                            o_cmd.emit       = 1'b1;
                            o_cmd.tick       = 1'b1;
                            o_cmd.res_status = tevq_pkg::ST_ADVANCED;
                            o_cmd.res_last   = 1'b1;
                        end
                        default: begin
                            // unused action: no result
                            o_cmd.emit = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/tevq_dpath.sv @@
// ============================================================================
// tevq_dpath: datapath for the timed event queue
// Time counter, sorted shift array of jobs, input latch and result register.
// ============================================================================
`default_nettype none

module tevq_dpath #(
    parameter int QUEUE_DEPTH = tevq_pkg::QueueDepthDef,
    parameter int NODE_BITS   = tevq_pkg::NodeBitsDef,
    parameter int PACKET_BITS = tevq_pkg::PacketBitsDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tevq_pkg::t_dp_cmd  i_cmd,
    output tevq_pkg::t_dp_stat      o_stat,
    input  wire tevq_pkg::t_in_word i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output tevq_pkg::t_out_word     o_out_data
);

    // Input latch, precomputed due time, current time
    tevq_pkg::t_in_word r_in;
    logic [31:0]        r_due;
    logic [31:0]        r_now;

    // Job array, sorted by due time, valid entries form a prefix
    logic [QUEUE_DEPTH-1:0] r_valid;
    logic [31:0]            r_due_time [QUEUE_DEPTH];
    logic [1:0]             r_kind     [QUEUE_DEPTH];
    logic [NODE_BITS-1:0]   r_node     [QUEUE_DEPTH];
    logic [7:0]             r_dest     [QUEUE_DEPTH];
    logic [7:0]             r_link     [QUEUE_DEPTH];
    logic [PACKET_BITS-1:0] r_packet   [QUEUE_DEPTH];

    // Result register
    logic                r_out_valid;
    tevq_pkg::t_out_word r_out;

    // New job fields
    logic [NODE_BITS-1:0]   new_node;
    logic [7:0]             new_dest;
    logic [7:0]             new_link;
    logic [PACKET_BITS-1:0] new_packet;

    // Entries that stay ahead of the new job
    logic [QUEUE_DEPTH-1:0] keep;

    assign new_node   = NODE_BITS'(r_in.node_id);
    assign new_dest   = (r_in.job_kind == tevq_pkg::KIND_CREATE) ? r_in.dest_id
                                                                 : tevq_pkg::NONE_ID;
    assign new_link   = (r_in.job_kind >= tevq_pkg::KIND_UPLOAD) ? r_in.link_id
                                                                 : tevq_pkg::NONE_ID;
    assign new_packet = (r_in.job_kind == tevq_pkg::KIND_CREATE) ? '0
                                                                 : PACKET_BITS'(r_in.packet_ref);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            keep[i] = r_valid[i] && (r_due_time[i] <= r_due);
        end
    end

    // Status to controller
    assign o_stat.action   = tevq_pkg::t_action'(r_in.action);
    assign o_stat.full     = r_valid[QUEUE_DEPTH-1];
    assign o_stat.head_due = r_valid[0] && (r_due_time[0] == r_now);
    assign o_stat.next_due = r_valid[1] && (r_due_time[1] == r_now);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Input latch and due time
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in  <= i_in_data;
            r_due <= r_now + 32'(i_in_data.delay);
        end
    end

    // Current time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= tevq_pkg::TIME_RESET;
        end else if (i_cmd.tick) begin
            r_now <= r_now + 32'd1;
        end
    end

    // Shift array slots: insert shifts up, pop shifts down
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
        localparam int Up = (g == 0) ? 0 : g - 1;
        localparam int Dn = (g == QUEUE_DEPTH - 1) ? g : g + 1;

        logic up_keep;
        logic take_new;
        logic take_up;

        assign up_keep  = (g == 0) ? 1'b1 : keep[Up];
        assign take_new = i_cmd.insert && !keep[g] && up_keep;
        assign take_up  = i_cmd.insert && !keep[g] && !up_keep;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (take_new) begin
                r_valid[g] <= 1'b1;
            end else if (take_up) begin
                r_valid[g] <= r_valid[Up];
            end else if (i_cmd.pop) begin
                r_valid[g] <= (g == QUEUE_DEPTH - 1) ? 1'b0 : r_valid[Dn];
            end
        end

        always_ff @(posedge i_clk) begin
            if (take_new) begin
                r_due_time[g] <= r_due;
                r_kind[g]     <= r_in.job_kind;
                r_node[g]     <= new_node;
                r_dest[g]     <= new_dest;
                r_link[g]     <= new_link;
                r_packet[g]   <= new_packet;
            end else if (take_up) begin
                r_due_time[g] <= r_due_time[Up];
                r_kind[g]     <= r_kind[Up];
                r_node[g]     <= r_node[Up];
                r_dest[g]     <= r_dest[Up];
                r_link[g]     <= r_link[Up];
                r_packet[g]   <= r_packet[Up];
            end else if (i_cmd.pop) begin
                r_due_time[g] <= r_due_time[Dn];
                r_kind[g]     <= r_kind[Dn];
                r_node[g]     <= r_node[Dn];
                r_dest[g]     <= r_dest[Dn];
                r_link[g]     <= r_link[Dn];
                r_packet[g]   <= r_packet[Dn];
            end
        end
    end

    // Result valid: set on emit, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result word; job fields only for a due job
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.status   <= i_cmd.res_status;
            r_out.now_time <= i_cmd.tick ? (r_now + 32'd1) : r_now;
            r_out.last     <= i_cmd.res_last;
            if (i_cmd.res_status == tevq_pkg::ST_DUE) begin
                r_out.job_kind_res   <= r_kind[0];
                r_out.node_id_res    <= 8'(r_node[0]);
                r_out.dest_id_res    <= r_dest[0];
                r_out.link_id_res    <= r_link[0];
                r_out.packet_ref_res <= 16'(r_packet[0]);
            end else begin
                r_out.job_kind_res   <= '0;
                r_out.node_id_res    <= '0;
                r_out.dest_id_res    <= '0;
                r_out.link_id_res    <= '0;
                r_out.packet_ref_res <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/timed_event_queue.sv @@
// ============================================================================
// timed_event_queue: discrete-event job queue kept in due-time order
// Top level joining the sequencing controller and the job datapath.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one word per
//   item: schedule a job at now + delay, drain jobs due now, or advance time.
//   Result channel (o_out_valid / i_out_ready / o_out_data) returns one word
//   for schedule and advance, one word per due job for a drain (last marks
//   the final one) or a single none-due word. The unused action code gives
//   no result.
//   Flow: a word is taken in the idle state and worked in the execute
//   state once the result slot is free; a drain pops due jobs one per
//   cycle, while the slot is free, through the head of the shift array.
//   The result is registered and appears in the cycle after it is worked.
//   A registered result slot parts the channels: the next word is taken
//   while a result still waits. When the receiver stalls, work stops in the
//   execute step until the slot frees; nothing is lost.
//   Reset empties the queue, clears the result slot and sets time to 1.
// ============================================================================
`default_nettype none

module timed_event_queue #(
    parameter int QUEUE_DEPTH = tevq_pkg::QueueDepthDef,
    parameter int NODE_BITS   = tevq_pkg::NodeBitsDef,
    parameter int PACKET_BITS = tevq_pkg::PacketBitsDef
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tevq_pkg::t_in_word  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tevq_pkg::t_out_word      o_out_data
);

    tevq_pkg::t_dp_cmd  cmd;
    tevq_pkg::t_dp_stat stat;

    // Controller
    tevq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath
    tevq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NODE_BITS   (NODE_BITS),
        .PACKET_BITS (PACKET_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ hw/rtl/tevq_chk.sv @@
// ============================================================================
// tevq_chk: port checker for the timed event queue
// Watches the top-level ports over time; bound to the top level.
// ============================================================================
`default_nettype none

module tevq_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire tevq_pkg::t_out_word o_out_data
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // Reset empties the result slot
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // One word at a time: ready drops after a take
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken back to back");

    // Non-job results carry zero job fields and are always last
    a_nonjob_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != tevq_pkg::ST_DUE) |->
            o_out_data.last && (o_out_data.job_kind_res == '0) &&
            (o_out_data.node_id_res == '0) && (o_out_data.dest_id_res == '0) &&
            (o_out_data.link_id_res == '0) && (o_out_data.packet_ref_res == '0))
        else $error("non-job result word malformed");

endmodule

bind timed_event_queue tevq_chk u_tevq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

@@ tb/tb_timed_event_queue.sv @@
// ============================================================================
// tb_timed_event_queue: self-checking bench for the timed event queue
// Drives schedule, drain and advance words through the valid/ready input
// channel and checks every result word, field by field, against a queue
// model kept in the bench. A short directed pass hits the edges (empty and
// full queue, equal due times, field extremes); random job bursts follow,
// under varying idle and stall patterns and one long receiver hold-off. The
// blocked-by-overdue-head case runs last, since it jams the queue for good.
// ============================================================================
`default_nettype none

module tb_timed_event_queue;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 100;
    localparam int SETTLE_CYCLES  = 10;

    // Action code the block ignores
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic [31:0] due;
        logic [1:0]  kind;
        logic [7:0]  node;
        logic [7:0]  dest;
        logic [7:0]  link;
        logic [15:0] pkt;
    } t_pending_job;

    // One offered word, with its result typed in when typed is set
    typedef struct {
        tevq_pkg::t_in_word  word;
        bit                  typed;
        tevq_pkg::t_out_word result;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    tevq_pkg::t_in_word  i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    tevq_pkg::t_out_word o_out_data;

    // Queue model state
    logic [31:0]         now_ticks = tevq_pkg::TIME_RESET;
    t_pending_job        job_list[$];
    tevq_pkg::t_out_word step_words[$];

    // Scoreboard
    t_stim_row           offered_rows[$];
    tevq_pkg::t_out_word awaited_results[$];
    int                  mismatches = 0;
    int                  quiet_cycles = 0;

    // Traffic shaping
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_served    = 0;

    t_stim_row directed_rows[$];
    t_stim_row overdue_rows[$];

    timed_event_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic tevq_pkg::t_in_word mk_word(logic [1:0] act, logic [1:0] kind,
                                                   logic [7:0] node, logic [7:0] dest,
                                                   logic [7:0] link, logic [15:0] pkt,
                                                   logic [15:0] dly);
        tevq_pkg::t_in_word w;
        w.action     = act;
        w.job_kind   = kind;
        w.node_id    = node;
        w.dest_id    = dest;
        w.link_id    = link;
        w.packet_ref = pkt;
        w.delay      = dly;
        return w;
    endfunction

    function automatic tevq_pkg::t_in_word rand_word(logic [1:0] act, logic [15:0] dly);
        return mk_word(act, 2'($urandom_range(3)), 8'($urandom_range(254)),
                       8'($urandom), 8'($urandom), 16'($urandom), dly);
    endfunction

    // Single word with no job fields, as for schedule, advance, none due
    function automatic tevq_pkg::t_out_word mk_res(tevq_pkg::t_status st,
                                                   logic [31:0] now);
        tevq_pkg::t_out_word r;
        r          = '0;
        r.status   = st;
        r.now_time = now;
        r.last     = 1'b1;
        return r;
    endfunction

    function automatic t_stim_row mk_row(tevq_pkg::t_in_word w, bit typed,
                                         tevq_pkg::t_out_word res);
        t_stim_row r;
        r.word   = w;
        r.typed  = typed;
        r.result = res;
        return r;
    endfunction

    // Apply one accepted word to the queue model; results land in step_words
    function automatic void step_queue_model(tevq_pkg::t_in_word w);
        t_pending_job        job;
        tevq_pkg::t_out_word res;
        int                  pos;
        step_words.delete();
        case (w.action)
            tevq_pkg::ACT_SCHED: begin
                if (job_list.size() >= tevq_pkg::QueueDepthDef) begin
                    step_words.insert(step_words.size(),
                                      mk_res(tevq_pkg::ST_DROPPED, now_ticks));
                end else begin
                    job.due  = now_ticks + 32'(w.delay);
                    job.kind = w.job_kind;
                    job.node = w.node_id;
                    job.dest = (w.job_kind == tevq_pkg::KIND_CREATE) ? w.dest_id
                                                                     : tevq_pkg::NONE_ID;
                    job.link = (w.job_kind >= tevq_pkg::KIND_UPLOAD) ? w.link_id
                                                                     : tevq_pkg::NONE_ID;
                    job.pkt  = (w.job_kind == tevq_pkg::KIND_CREATE) ? 16'd0
                                                                     : w.packet_ref;
                    // behind every job with the same or earlier due time
                    pos = 0;
                    while (pos < job_list.size() && job_list[pos].due <= job.due)
                        pos++;
                    job_list.insert(pos, job);
                    step_words.insert(step_words.size(),
                                      mk_res(tevq_pkg::ST_SCHEDULED, now_ticks));
                end
            end
            tevq_pkg::ACT_DRAIN: begin
                // pop only while the head is due exactly now
                while (job_list.size() != 0 && job_list[0].due == now_ticks) begin
                    res                = '0;
                    res.status         = tevq_pkg::ST_DUE;
                    res.job_kind_res   = job_list[0].kind;
                    res.node_id_res    = job_list[0].node;
                    res.dest_id_res    = job_list[0].dest;
                    res.link_id_res    = job_list[0].link;
                    res.packet_ref_res = job_list[0].pkt;
                    res.now_time       = now_ticks;
                    step_words.insert(step_words.size(), res);
                    void'(job_list.pop_front());
                end
                if (step_words.size() == 0)
                    step_words.insert(0, mk_res(tevq_pkg::ST_NONE_DUE, now_ticks));
                else
                    step_words[step_words.size() - 1].last = 1'b1;
            end
            tevq_pkg::ACT_ADVANCE: begin
                now_ticks = now_ticks + 32'd1;
                step_words.insert(step_words.size(),
                                  mk_res(tevq_pkg::ST_ADVANCED, now_ticks));
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic offer_word(t_stim_row row);
        offered_rows.insert(offered_rows.size(), row);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= row.word;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Input acceptance feeds the model; result acceptance is checked
    always @(posedge i_clk) begin
        t_stim_row           row;
        tevq_pkg::t_out_word want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            row = offered_rows.pop_front();
            step_queue_model(i_in_data);
            if (row.typed)
                awaited_results.insert(awaited_results.size(), row.result);
            else
                foreach (step_words[k])
                    awaited_results.insert(awaited_results.size(), step_words[k]);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result word with status %0d arrived, none expected",
                       o_out_data.status);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", want.status, o_out_data.status);
                check_field("job_kind_res", want.job_kind_res, o_out_data.job_kind_res);
                check_field("node_id_res", want.node_id_res, o_out_data.node_id_res);
                check_field("dest_id_res", want.dest_id_res, o_out_data.dest_id_res);
                check_field("link_id_res", want.link_id_res, o_out_data.link_id_res);
                check_field("packet_ref_res", want.packet_ref_res,
                            o_out_data.packet_ref_res);
                check_field("now_time", want.now_time, o_out_data.now_time);
                check_field("last", want.last, o_out_data.last);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_asked) begin
                hold_served++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: too long with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_timed_event_queue: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_stim_row seq_rows[$];
        t_stim_row noise;
        int        sent;
        int        seq;
        int        n_jobs;
        int        pick;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;

        // Directed words: empty drain, advance, ignored action, full queue of
        // jobs all due now, drop on full, 16-job drain in order, delayed job
        directed_rows.insert(directed_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_DRAIN, 0, 0, 0, 0, 0, 0), 1,
                   mk_res(tevq_pkg::ST_NONE_DUE, tevq_pkg::TIME_RESET)));
        directed_rows.insert(directed_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_ADVANCE, 0, 0, 0, 0, 0, 0), 1,
                   mk_res(tevq_pkg::ST_ADVANCED, tevq_pkg::TIME_RESET + 1)));
        directed_rows.insert(directed_rows.size(),
            mk_row(mk_word(ACT_SPARE, 2'd3, 8'd254, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF),
                   0, '0));
        for (int i = 0; i < tevq_pkg::QueueDepthDef; i++) begin
            directed_rows.insert(directed_rows.size(), mk_row(
                mk_word(tevq_pkg::ACT_SCHED, 2'(i % 4), (i % 2 == 0) ? 8'd0 : 8'd254,
                        (i < 8) ? 8'(i) : tevq_pkg::NONE_ID,
                        (i % 3 == 0) ? 8'd0 : tevq_pkg::NONE_ID,
                        16'hFFFF - 16'(i * 4096), 16'd0),
                1, mk_res(tevq_pkg::ST_SCHEDULED, tevq_pkg::TIME_RESET + 1)));
        end
        directed_rows.insert(directed_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_SCHED, 2'd3, 8'd254, 8'hFF, 8'hFF,
                           16'hFFFF, 16'hFFFF), 1,
                   mk_res(tevq_pkg::ST_DROPPED, tevq_pkg::TIME_RESET + 1)));
        directed_rows.insert(directed_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_DRAIN, 0, 0, 0, 0, 0, 0), 0, '0));
        directed_rows.insert(directed_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_DRAIN, 0, 0, 0, 0, 0, 0), 1,
                   mk_res(tevq_pkg::ST_NONE_DUE, tevq_pkg::TIME_RESET + 1)));
        directed_rows.insert(directed_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_SCHED, tevq_pkg::KIND_CREATE, 8'd17, 8'd5,
                           8'd9, 16'h1234, 16'd1), 1,
                   mk_res(tevq_pkg::ST_SCHEDULED, tevq_pkg::TIME_RESET + 1)));
        directed_rows.insert(directed_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_ADVANCE, 0, 0, 0, 0, 0, 0), 1,
                   mk_res(tevq_pkg::ST_ADVANCED, tevq_pkg::TIME_RESET + 2)));
        directed_rows.insert(directed_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_DRAIN, 0, 0, 0, 0, 0, 0), 0, '0));

        // Overdue head: a job left past its due time is never popped and
        // blocks the later job behind it
        overdue_rows.insert(overdue_rows.size(),
            mk_row(rand_word(tevq_pkg::ACT_SCHED, 16'd0), 0, '0));
        overdue_rows.insert(overdue_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_ADVANCE, 0, 0, 0, 0, 0, 0), 0, '0));
        overdue_rows.insert(overdue_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_DRAIN, 0, 0, 0, 0, 0, 0), 0, '0));
        overdue_rows.insert(overdue_rows.size(),
            mk_row(rand_word(tevq_pkg::ACT_SCHED, 16'd1), 0, '0));
        overdue_rows.insert(overdue_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_ADVANCE, 0, 0, 0, 0, 0, 0), 0, '0));
        overdue_rows.insert(overdue_rows.size(),
            mk_row(mk_word(tevq_pkg::ACT_DRAIN, 0, 0, 0, 0, 0, 0), 0, '0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) offer_word(directed_rows[i]);

        // Random bursts: a few jobs due within four ticks, then a drain at
        // every tick before advancing, so nothing goes overdue
        sent = 0;
        seq  = 0;
        while (sent < RANDOM_ITEMS) begin
            case (seq % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (seq == 4) begin
                send_idle_pct = 0;
                hold_asked++;
            end

            seq_rows.delete();
            n_jobs = $urandom_range(1, 4);
            for (int j = 0; j < n_jobs; j++)
                seq_rows.insert(seq_rows.size(),
                    mk_row(rand_word(tevq_pkg::ACT_SCHED, 16'($urandom_range(3))),
                           0, '0));
            for (int j = 0; j < 4; j++) begin
                seq_rows.insert(seq_rows.size(),
                    mk_row(mk_word(tevq_pkg::ACT_DRAIN, 0, 0, 0, 0, 0, 0), 0, '0));
                seq_rows.insert(seq_rows.size(),
                    mk_row(mk_word(tevq_pkg::ACT_ADVANCE, 0, 0, 0, 0, 0, 0), 0, '0));
            end
            sent += seq_rows.size();

            // noise: ignored action, stray drain, or a far-off job
            if ($urandom_range(2) == 0) begin
                pick = $urandom_range(2);
                if (pick == 0) begin
                    noise = mk_row(rand_word(ACT_SPARE, 16'($urandom)), 0, '0);
                end else if (pick == 1) begin
                    noise = mk_row(mk_word(tevq_pkg::ACT_DRAIN, 0, 0, 0, 0, 0, 0),
                                   0, '0);
                    sent++;
                end else begin
                    noise = mk_row(rand_word(tevq_pkg::ACT_SCHED, 16'($urandom)),
                                   0, '0);
                    sent++;
                end
                seq_rows.insert($urandom_range(seq_rows.size()), noise);
            end

            foreach (seq_rows[i]) offer_word(seq_rows[i]);
            seq++;
        end

        send_idle_pct  = 23;
        recv_stall_pct = 23;
        foreach (overdue_rows[i]) offer_word(overdue_rows[i]);

        // Drain outstanding results, then watch for strays
        i_in_valid     <= 1'b0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_timed_event_queue: clean");
        else
            $display("tb_timed_event_queue: errors");
        $finish;
    end

endmodule

`default_nettype wire
